[src/cbjd_pkg.sv]
// cbjd_pkg: constants, types and lookup tables shared by the camera block jpeg deframer
// no dependencies; every other file of the block but cbjd_ifs refers to it by scoped names
package cbjd_pkg;

   // stream geometry
   localparam int DATA_BYTES   = 500;
   localparam int HEADER_BYTES = 12;
   localparam int MAGIC_LEN    = 5;
   localparam int MAX_RESULTS  = 5;
   localparam int QUEUE_DEPTH  = 4;

   // derived widths
   localparam int BLK_W       = $clog2(DATA_BYTES + 1);
   localparam int HDR_W       = $clog2(HEADER_BYTES + 1);
   localparam int MATCH_W     = $clog2(MAGIC_LEN + 1);
   localparam int MAGIC_IDX_W = $clog2(MAGIC_LEN);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // jpeg marker bytes
   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] SOI_CODE      = 8'hD8;
   localparam logic [7:0] EOI_CODE      = 8'hD9;

   // block header magic
   localparam logic [7:0] MAGIC [MAGIC_LEN] = '{8'hAA, 8'hBB, 8'h07, 8'hFB, 8'h01};

   // position within the current frame
   localparam logic [1:0] POS_START  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_BODY   = 2'd2;

   // parser modes
   typedef enum logic [2:0] {
      MODE_HUNT,
      MODE_HEADER,
      MODE_DATA,
      MODE_BOUNDARY,
      MODE_RUNON
   } mode_type;

   // one queue entry: every result caused by one input word
   // results are: FF when first, then magic prefix bytes, then data as the final one
   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic             first;
      logic             eoi;
      logic [7:0]       data;
   } pkt_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

[src/cbjd_ifs.sv]
// channel interfaces of the camera block jpeg deframer: input, result and csr write
// no dependencies
interface cbjd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

interface cbjd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] jpeg_byte;
   logic       frame_first;
   logic       frame_last;
   logic       run_last;

   modport source (output valid, output jpeg_byte, output frame_first,
                   output frame_last, output run_last, input ready);
   modport sink (input valid, input jpeg_byte, input frame_first,
                 input frame_last, input run_last, output ready);
endinterface

interface cbjd_csr_if;
   logic valid;
   logic ready;
   logic skip_first_frame;

   modport source (output valid, output skip_first_frame, input ready);
   modport sink (input valid, input skip_first_frame, output ready);
endinterface

[src/cbjd_front.sv]
// cbjd_front: parser for the camera byte stream; hunts headers, tracks frames and
// writes one queue entry per input word that yields results
// depends on cbjd_pkg and cbjd_ifs
module cbjd_front (
   input  logic                clock,
   input  logic                reset,
   cbjd_req_if.sink            req,
   cbjd_csr_if.sink            csr,
   input  cbjd_pkg::qstat_type qstat,
   output logic                push,
   output cbjd_pkg::pkt_type   pkt
);

   localparam cbjd_pkg::mode_type HDR_ENTRY_MODE =
      (cbjd_pkg::HEADER_BYTES <= cbjd_pkg::MAGIC_LEN) ? cbjd_pkg::MODE_DATA
                                                      : cbjd_pkg::MODE_HEADER;

   cbjd_pkg::mode_type                mode_ff, mode_in;
   logic [cbjd_pkg::MATCH_W-1:0]      match_ff, match_in;
   logic [cbjd_pkg::HDR_W-1:0]        hdr_ff, hdr_in;
   logic [cbjd_pkg::BLK_W-1:0]        blk_ff, blk_in;
   logic                              prev_ff, prev_in;
   logic [1:0]                        pos_ff, pos_in;
   logic                              emit_ff, emit_in;
   logic                              seen_ff, seen_in;
   logic                              skip_ff;

   logic                              fire;
   logic [7:0]                        b;
   logic                              eoi_w, soi_w;
   logic                              magic_hit;
   logic [cbjd_pkg::MATCH_W-1:0]      match_inc, hunt_match;
   logic                              hunt_done, bnd_done, bnd_eoi;
   logic                              data_end;
   logic [cbjd_pkg::BLK_W-1:0]        blk_inc;
   logic [cbjd_pkg::HDR_W-1:0]        hdr_inc;
   logic                              blk_full, hdr_full;
   logic                              push_w;

   // data step results for one byte of a frame
   logic                              ds_prev, ds_emit, ds_seen, ds_push, ds_first;
   logic                              ds_end, ds_eoi;
   logic [1:0]                        ds_pos;
   logic [cbjd_pkg::CNT_W-1:0]        ds_cnt;

   // handshakes
   assign req.ready = !qstat.full;
   assign csr.ready = 1'b1;
   assign fire      = req.valid && req.ready;
   assign b         = req.stream_byte;
   assign push      = fire && push_w;

   // byte classification
   assign eoi_w     = prev_ff && (b == cbjd_pkg::EOI_CODE);
   assign soi_w     = prev_ff && (b == cbjd_pkg::SOI_CODE);
   assign magic_hit = (match_ff < cbjd_pkg::MATCH_W'(cbjd_pkg::MAGIC_LEN)) &&
                      (b == cbjd_pkg::MAGIC[match_ff[cbjd_pkg::MAGIC_IDX_W-1:0]]);
   assign match_inc = match_ff + cbjd_pkg::MATCH_W'(1);
   assign hunt_match = magic_hit ? match_inc :
                       ((b == cbjd_pkg::MAGIC[0]) ? cbjd_pkg::MATCH_W'(1)
                                                   : cbjd_pkg::MATCH_W'(0));
   assign hunt_done = hunt_match == cbjd_pkg::MATCH_W'(cbjd_pkg::MAGIC_LEN);
   assign bnd_done  = magic_hit && (match_inc == cbjd_pkg::MATCH_W'(cbjd_pkg::MAGIC_LEN));
   // a failed boundary check can only close the frame when nothing of the magic matched
   assign bnd_eoi   = !magic_hit && (match_ff == '0) && eoi_w;
   assign data_end  = (pos_ff != cbjd_pkg::POS_START) && eoi_w;
   assign blk_inc   = blk_ff + cbjd_pkg::BLK_W'(1);
   assign hdr_inc   = hdr_ff + cbjd_pkg::HDR_W'(1);
   assign blk_full  = blk_inc >= cbjd_pkg::BLK_W'(cbjd_pkg::DATA_BYTES);
   assign hdr_full  = hdr_inc >= cbjd_pkg::HDR_W'(cbjd_pkg::HEADER_BYTES);

   // one frame byte: soi detection, skipping and eoi
   always_comb begin
      ds_prev  = prev_ff;
      ds_pos   = pos_ff;
      ds_emit  = emit_ff;
      ds_seen  = seen_ff;
      ds_push  = 1'b0;
      ds_cnt   = '0;
      ds_first = 1'b0;
      ds_end   = 1'b0;
      ds_eoi   = 1'b0;
      case (pos_ff)
         cbjd_pkg::POS_START: begin
            ds_prev = b == cbjd_pkg::MARKER_PREFIX;
            ds_pos  = cbjd_pkg::POS_SECOND;
         end
         cbjd_pkg::POS_SECOND: begin
            if (soi_w) begin
               ds_emit  = !(skip_ff && !seen_ff);
               ds_push  = !(skip_ff && !seen_ff);
               ds_cnt   = cbjd_pkg::CNT_W'(2);
               ds_first = 1'b1;
               ds_seen  = 1'b1;
               ds_pos   = cbjd_pkg::POS_BODY;
               ds_prev  = 1'b0;
            end else if (eoi_w) begin
               ds_end = 1'b1;
            end else begin
               ds_pos  = cbjd_pkg::POS_BODY;
               ds_prev = b == cbjd_pkg::MARKER_PREFIX;
            end
         end
         default: begin
            ds_push = emit_ff;
            ds_cnt  = cbjd_pkg::CNT_W'(1);
            ds_eoi  = eoi_w;
            if (eoi_w) begin
               ds_end = 1'b1;
            end else begin
               ds_prev = b == cbjd_pkg::MARKER_PREFIX;
            end
         end
      endcase
      if (ds_end) begin
         ds_prev = 1'b0;
         ds_pos  = cbjd_pkg::POS_START;
         ds_emit = 1'b0;
      end
   end

   // next parser mode
   always_comb begin
      case (mode_ff)
         cbjd_pkg::MODE_HEADER:
            mode_in = hdr_full ? cbjd_pkg::MODE_DATA : cbjd_pkg::MODE_HEADER;
         cbjd_pkg::MODE_DATA: begin
            if (data_end) begin
               mode_in = cbjd_pkg::MODE_HUNT;
            end else if (blk_full) begin
               mode_in = cbjd_pkg::MODE_BOUNDARY;
            end else begin
               mode_in = cbjd_pkg::MODE_DATA;
            end
         end
         cbjd_pkg::MODE_BOUNDARY: begin
            if (magic_hit) begin
               mode_in = bnd_done ? HDR_ENTRY_MODE : cbjd_pkg::MODE_BOUNDARY;
            end else begin
               mode_in = bnd_eoi ? cbjd_pkg::MODE_HUNT : cbjd_pkg::MODE_RUNON;
            end
         end
         cbjd_pkg::MODE_RUNON:
            mode_in = data_end ? cbjd_pkg::MODE_HUNT : cbjd_pkg::MODE_RUNON;
         default:
            mode_in = hunt_done ? HDR_ENTRY_MODE : cbjd_pkg::MODE_HUNT;
      endcase
   end

   // counters, frame flags and the queue entry
   always_comb begin
      match_in  = match_ff;
      hdr_in    = hdr_ff;
      blk_in    = blk_ff;
      prev_in   = prev_ff;
      pos_in    = pos_ff;
      emit_in   = emit_ff;
      seen_in   = seen_ff;
      push_w    = 1'b0;
      pkt.cnt   = '0;
      pkt.first = 1'b0;
      pkt.eoi   = 1'b0;
      pkt.data  = b;
      case (mode_ff)
         cbjd_pkg::MODE_HEADER: begin
            hdr_in = hdr_inc;
            if (hdr_full) begin
               blk_in = '0;
            end
         end
         cbjd_pkg::MODE_DATA, cbjd_pkg::MODE_RUNON: begin
            prev_in   = ds_prev;
            pos_in    = ds_pos;
            emit_in   = ds_emit;
            seen_in   = ds_seen;
            push_w    = ds_push;
            pkt.cnt   = ds_cnt;
            pkt.first = ds_first;
            pkt.eoi   = ds_eoi;
            if (ds_end) begin
               match_in = '0;
            end else if (mode_ff == cbjd_pkg::MODE_DATA) begin
               blk_in = blk_inc;
               if (blk_full) begin
                  match_in = '0;
               end
            end
         end
         cbjd_pkg::MODE_BOUNDARY: begin
            if (magic_hit) begin
               match_in = match_inc;
               if (bnd_done) begin
                  match_in = '0;
                  hdr_in   = cbjd_pkg::HDR_W'(cbjd_pkg::MAGIC_LEN);
                  blk_in   = '0;
                  prev_in  = 1'b0;
               end
            end else begin
               // held magic bytes and this byte all become frame data
               match_in = '0;
               push_w   = emit_ff;
               pkt.cnt  = cbjd_pkg::CNT_W'(match_ff) + cbjd_pkg::CNT_W'(1);
               pkt.eoi  = bnd_eoi;
               if (bnd_eoi) begin
                  prev_in = 1'b0;
                  pos_in  = cbjd_pkg::POS_START;
                  emit_in = 1'b0;
               end else begin
                  prev_in = b == cbjd_pkg::MARKER_PREFIX;
               end
            end
         end
         default: begin
            match_in = hunt_match;
            if (hunt_done) begin
               match_in = '0;
               pos_in   = cbjd_pkg::POS_START;
               emit_in  = 1'b0;
               hdr_in   = cbjd_pkg::HDR_W'(cbjd_pkg::MAGIC_LEN);
               blk_in   = '0;
               prev_in  = 1'b0;
            end
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= cbjd_pkg::MODE_HUNT;
         match_ff <= '0;
         hdr_ff   <= '0;
         blk_ff   <= '0;
         prev_ff  <= 1'b0;
         pos_ff   <= cbjd_pkg::POS_START;
         emit_ff  <= 1'b0;
         seen_ff  <= 1'b0;
         skip_ff  <= 1'b1;
      end else begin
         if (csr.valid && csr.ready) begin
            skip_ff <= csr.skip_first_frame;
         end
         if (fire) begin
            mode_ff  <= mode_in;
            match_ff <= match_in;
            hdr_ff   <= hdr_in;
            blk_ff   <= blk_in;
            prev_ff  <= prev_in;
            pos_ff   <= pos_in;
            emit_ff  <= emit_in;
            seen_ff  <= seen_in;
         end
      end
   end

   // a block boundary is only reached well inside a frame
   assert property (@(posedge clock) disable iff (reset)
      mode_ff == cbjd_pkg::MODE_BOUNDARY |-> pos_ff == cbjd_pkg::POS_BODY)
      else $error("boundary check outside frame body");

   // the held magic prefix never reaches the full magic length
   assert property (@(posedge clock) disable iff (reset)
      match_ff < cbjd_pkg::MATCH_W'(cbjd_pkg::MAGIC_LEN))
      else $error("magic match count out of range");

   // a frame is only passed on once the first soi has been seen
   assert property (@(posedge clock) disable iff (reset)
      emit_ff |-> seen_ff)
      else $error("emitting before any soi");

endmodule

[src/cbjd_queue.sv]
// cbjd_queue: short fifo of result entries between parser and output sequencer
// depends on cbjd_pkg
module cbjd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cbjd_pkg::pkt_type   pkt_in,
   input  logic                pop,
   output cbjd_pkg::pkt_type   head,
   output cbjd_pkg::qstat_type qstat
);

   cbjd_pkg::pkt_type              entry_ff [cbjd_pkg::QUEUE_DEPTH];
   logic [cbjd_pkg::QPTR_W-1:0]    wr_ff, wr_in;
   logic [cbjd_pkg::QPTR_W-1:0]    rd_ff, rd_in;
   logic [cbjd_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign qstat.full  = count_ff == cbjd_pkg::QCNT_W'(cbjd_pkg::QUEUE_DEPTH);
   assign qstat.empty = count_ff == '0;
   assign head        = entry_ff[rd_ff];

   // pointer and fill count
   always_comb begin
      wr_in    = push ? wr_ff + cbjd_pkg::QPTR_W'(1) : wr_ff;
      rd_in    = pop ? rd_ff + cbjd_pkg::QPTR_W'(1) : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + cbjd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - cbjd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= pkt_in;
      end
   end

endmodule

[src/cbjd_back.sv]
// cbjd_back: output sequencer; expands each queue entry into result words one per cycle while rsp is ready
// depends on cbjd_pkg and cbjd_ifs
module cbjd_back (
   input  logic                clock,
   input  logic                reset,
   input  cbjd_pkg::qstat_type qstat,
   input  cbjd_pkg::pkt_type   head,
   output logic                pop,
   cbjd_rsp_if.source          rsp
);

   cbjd_pkg::pkt_type             pkt_ff;
   logic                          busy_ff, busy_in;
   logic [cbjd_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic                          last_w, fire_w, first_w;
   logic [cbjd_pkg::CNT_W-1:0]    last_idx;

   assign last_idx = pkt_ff.cnt - cbjd_pkg::CNT_W'(1);
   assign last_w   = idx_ff == last_idx;
   assign fire_w   = rsp.valid && rsp.ready;
   assign pop      = !qstat.empty && (!busy_ff || (fire_w && last_w));
   assign first_w  = pkt_ff.first && (idx_ff == '0);

   // result word
   assign rsp.valid       = busy_ff;
   assign rsp.frame_first = first_w;
   assign rsp.frame_last  = pkt_ff.eoi && last_w;
   assign rsp.run_last    = last_w;
   assign rsp.jpeg_byte   = first_w ? cbjd_pkg::MARKER_PREFIX :
                            (idx_ff < last_idx) ?
                               cbjd_pkg::MAGIC[idx_ff[cbjd_pkg::MAGIC_IDX_W-1:0]] :
                               pkt_ff.data;

   // word index within the entry
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (fire_w) begin
         if (last_w) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + cbjd_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // entry holding register
   always_ff @(posedge clock) begin
      if (pop) begin
         pkt_ff <= head;
      end
   end

   // a loaded entry always carries one to five words
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pkt_ff.cnt != '0) &&
                  (pkt_ff.cnt <= cbjd_pkg::CNT_W'(cbjd_pkg::MAX_RESULTS)))
      else $error("bad result count in entry");

   // a frame opening entry is exactly the two soi words
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && pkt_ff.first) |-> pkt_ff.cnt == cbjd_pkg::CNT_W'(2))
      else $error("soi entry with wrong length");

   // a taken word that is not the last moves on to the next word of the same entry
   assert property (@(posedge clock) disable iff (reset)
      (fire_w && !last_w) |=> busy_ff && (idx_ff == $past(idx_ff) + cbjd_pkg::CNT_W'(1)))
      else $error("entry sequencing lost a word");

endmodule

[src/camera_block_jpeg_deframer.sv]
// camera_block_jpeg_deframer: top level; parser, entry queue and output sequencer
// depends on cbjd_pkg, cbjd_ifs, cbjd_front, cbjd_queue and cbjd_back
//
//   channel | dir | payload                                        | word
//   req     | in  | stream_byte[7:0]                               | one raw camera byte
//   rsp     | out | jpeg_byte[7:0], frame_first, frame_last, run_last | one frame byte
//   csr     | in  | skip_first_frame                               | register write
//
// one input word per cycle while the queue is not full; each yields zero to five result words,
// sent one per cycle by the output sequencer while rsp is ready
// a taken word passes the queue, then the output register, before its first result is offered
// req stalls only while the four-entry queue is full, i.e. after bursts of multi-word results or rsp stalls
// csr is always ready; rsp stalls hold the current word and fill the queue
// reset is synchronous: parser to hunting, queue and output emptied, skip_first_frame to 1
module camera_block_jpeg_deframer (
   input  logic       clock,
   input  logic       reset,
   cbjd_req_if.sink   req,
   cbjd_rsp_if.source rsp,
   cbjd_csr_if.sink   csr
);

   logic                push;
   logic                pop;
   cbjd_pkg::pkt_type   pkt;
   cbjd_pkg::pkt_type   head;
   cbjd_pkg::qstat_type qstat;

   // parser
   cbjd_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .csr   (csr),
      .qstat (qstat),
      .push  (push),
      .pkt   (pkt)
   );

   // entry queue
   cbjd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pkt_in (pkt),
      .pop    (pop),
      .head   (head),
      .qstat  (qstat)
   );

   // output sequencer
   cbjd_back u_back (
      .clock (clock),
      .reset (reset),
      .qstat (qstat),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule
